/* src/lmsd_pkg.sv */
`timescale 1ns / 1ps
package lmsd_pkg;

	localparam int ROWS_DEFAULT    = 8;
	localparam int COLUMNS_DEFAULT = 8;

	localparam int PIXEL_BITS = 24;
	localparam int INIT_BITS  = 144;
	localparam int ROW_PINS   = 8;

	localparam int HOLD_W   = 24;
	localparam int ROW_ON_W = 20;

	localparam logic [HOLD_W-1:0]   RESET_HOLD_DEFAULT = 24'd12000000;
	localparam logic [ROW_ON_W-1:0] ROW_ON_DEFAULT     = 20'd20000;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_RESET_HOLD = 1'b0;
	localparam logic REG_ROW_ON     = 1'b1;

	typedef enum logic [2:0] {
		PH_HOLD,
		PH_INIT_SHIFT,
		PH_INIT_LATCH,
		PH_ROW_SHIFT,
		PH_ROW_LATCH,
		PH_ROW_HOLD
	} phase_t;

	typedef struct packed {
		logic                data;
		logic                clock;
		logic                latch;
		logic                bank;
		logic                rst;
		logic [ROW_PINS-1:0] rows;
	} pins_t;

endpackage

/* src/lmsd_ram.sv */
`timescale 1ns / 1ps
module lmsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/lmsd_frame_store.sv */
`timescale 1ns / 1ps
module lmsd_frame_store #(
	parameter int ROWS    = lmsd_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = lmsd_pkg::COLUMNS_DEFAULT,
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [ROW_W-1:0]                 wr_row,
	input  logic [COL_W-1:0]                 wr_col,
	input  logic [lmsd_pkg::PIXEL_BITS-1:0]  wr_pixel,
	input  logic [ROW_W-1:0]                 rd_row,
	input  logic [COL_W-1:0]                 rd_col,
	output logic [lmsd_pkg::PIXEL_BITS-1:0]  rd_pixel
);
	import lmsd_pkg::*;

	localparam int DEPTH  = ROWS * COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     raddr;
	logic [PIXEL_BITS-1:0] ram_rdata;
	logic [DEPTH-1:0]      valid_q;
	logic                  rd_valid_q;
	logic                  byp_q;
	logic [PIXEL_BITS-1:0] byp_pixel_q;

	assign waddr = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col));
	assign raddr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(COLUMNS) + ADDR_W'(rd_col));

	lmsd_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_pixel),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// entries never written read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
			byp_q      <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_pixel_q <= wr_pixel;
	end

	assign rd_pixel = byp_q ? byp_pixel_q : (rd_valid_q ? ram_rdata : '0);

endmodule

/* src/lmsd_sequencer.sv */
`timescale 1ns / 1ps
module lmsd_sequencer #(
	parameter int ROWS    = lmsd_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = lmsd_pkg::COLUMNS_DEFAULT,
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [lmsd_pkg::HOLD_W-1:0]     reset_hold,
	input  logic [lmsd_pkg::ROW_ON_W-1:0]   row_on,
	input  logic [lmsd_pkg::PIXEL_BITS-1:0] pixel,
	output lmsd_pkg::pins_t                 pins,
	output logic [ROW_W-1:0]                rd_row,
	output logic [COL_W-1:0]                rd_col
);
	import lmsd_pkg::*;

	localparam int INIT_W = $clog2(INIT_BITS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [4:0] SUB_LAST = 5'(PIXEL_BITS - 1);

	phase_t              phase_q, phase_d;
	logic [INIT_W-1:0]   bit_q, bit_d;
	logic [4:0]          sub_q, sub_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic                half_q, half_d;
	logic [HOLD_W-1:0]   wait_q, wait_d;
	pins_t               pins_q, pins_d;
	logic                pix_bit;

	// blue, green, red bytes, msb first
	assign pix_bit = pixel[{sub_q[4:3], ~sub_q[2:0]}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HOLD;
			bit_q       <= '0;
			sub_q       <= '0;
			col_q       <= COL_LAST;
			row_q       <= '0;
			half_q      <= 1'b0;
			wait_q      <= '0;
			pins_q      <= '{data: 1'b0, clock: 1'b0, latch: 1'b1, bank: 1'b1, rst: 1'b0,
				rows: '0};
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			sub_q   <= sub_d;
			col_q   <= col_d;
			row_q   <= row_d;
			half_q  <= half_d;
			wait_q  <= wait_d;
			pins_q  <= pins_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		sub_d   = sub_q;
		col_d   = col_q;
		row_d   = row_q;
		half_d  = half_q;
		wait_d  = wait_q;
		pins_d  = pins_q;
		unique case (phase_q)
			PH_INIT_SHIFT: begin
				if (!half_q) begin
					pins_d.data  = 1'b1;
					pins_d.clock = 1'b0;
					half_d       = 1'b1;
				end else begin
					pins_d.clock = 1'b1;
					half_d       = 1'b0;
					if (bit_q == INIT_W'(INIT_BITS - 1)) begin
						bit_d   = '0;
						phase_d = PH_INIT_LATCH;
					end else begin
						bit_d = bit_q + 1'b1;
					end
				end
			end
			PH_INIT_LATCH: begin
				if (!half_q) begin
					pins_d.clock = 1'b0;
					pins_d.latch = 1'b0;
					half_d       = 1'b1;
				end else begin
					pins_d.latch = 1'b1;
					pins_d.bank  = 1'b1;
					half_d       = 1'b0;
					row_d        = '0;
					sub_d        = '0;
					col_d        = COL_LAST;
					phase_d      = PH_ROW_SHIFT;
				end
			end
			PH_ROW_SHIFT: begin
				if (!half_q) begin
					pins_d.data  = pix_bit;
					pins_d.clock = 1'b0;
					half_d       = 1'b1;
				end else begin
					pins_d.clock = 1'b1;
					half_d       = 1'b0;
					if (sub_q == SUB_LAST) begin
						sub_d = '0;
						if (col_q == '0) begin
							col_d   = COL_LAST;
							phase_d = PH_ROW_LATCH;
						end else begin
							col_d = col_q - 1'b1;
						end
					end else begin
						sub_d = sub_q + 1'b1;
					end
				end
			end
			PH_ROW_LATCH: begin
				if (!half_q) begin
					pins_d.clock = 1'b0;
					pins_d.latch = 1'b0;
					pins_d.rows  = (32'(row_q) < ROW_PINS) ?
						(ROW_PINS'(1) << row_q) : '0;
					half_d       = 1'b1;
				end else begin
					pins_d.latch = 1'b1;
					half_d       = 1'b0;
					wait_d       = '0;
					phase_d      = PH_ROW_HOLD;
				end
			end
			PH_ROW_HOLD: begin
				if (wait_q >= HOLD_W'(row_on)) begin
					pins_d.rows = '0;
					wait_d      = '0;
					sub_d       = '0;
					col_d       = COL_LAST;
					half_d      = 1'b0;
					row_d       = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
					phase_d     = PH_ROW_SHIFT;
				end else begin
					wait_d = wait_q + 1'b1;
				end
			end
			PH_HOLD: begin
				if (wait_q >= reset_hold) begin
					pins_d.rst  = 1'b1;
					pins_d.bank = 1'b0;
					wait_d      = '0;
					bit_d       = '0;
					half_d      = 1'b0;
					phase_d     = PH_INIT_SHIFT;
				end else begin
					wait_d = wait_q + 1'b1;
				end
			end
			default: begin
				phase_d = PH_HOLD;
			end
		endcase
	end

	// fetch the pixel for the state that holds after this cycle
	assign rd_row = step ? row_d : row_q;
	assign rd_col = step ? col_d : col_q;
	assign pins   = pins_q;

endmodule

/* src/led_matrix_scan_driver_unit.sv */
`timescale 1ns / 1ps
// LED matrix row-scan driver: frame store plus a pin sequencer for a
// serial constant-current driver and a row of one-hot row drives.
// Input channel (in_valid/in_ready): op selects a tick or a pixel write;
// a write stores red/green/blue at pixel_row/pixel_column, a tick steps
// the pin sequence by one step. Every item gives one output beat with the
// pin levels after the item (data, clock, latch, bank, driver reset, rows).
// Path: an input beat passes the input stage, then the output register.
// Throughput: one item per cycle while out_ready is high, set by a single
// input stage and one output register; the frame store is a one-write,
// one-read RAM with registered read, addressed by the next sequencer state.
// When out_ready is low the output beat holds, the input stage still takes
// one more item and then in_ready drops until the output drains.
// Reset: frame store reads as black (per-entry valid flops, no sweep),
// sequencer in its reset hold with latch and bank high, others low;
// hold and row-on times reset to their defaults.
// APB registers: 0x0 reset hold ticks (24 bit), 0x4 row-on ticks (20 bit).
module led_matrix_scan_driver_unit #(
	parameter int ROWS    = lmsd_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = lmsd_pkg::COLUMNS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [2:0]  pixel_row,
	input  logic [2:0]  pixel_column,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_pin,
	output logic        clock_pin,
	output logic        latch_pin,
	output logic        bank_pin,
	output logic        driver_reset_pin,
	output logic [7:0]  row_enables
);
	import lmsd_pkg::*;

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic [HOLD_W-1:0]     reset_hold_q;
	logic [ROW_ON_W-1:0]   row_on_q;
	logic                  cfg_wr;

	logic                  s1_valid_q;
	logic                  op_s1;
	logic [2:0]            row_s1;
	logic [2:0]            col_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic                  out_valid_q;
	logic                  advance;
	logic                  tick_go;
	logic                  wr_go;

	logic [ROW_W-1:0]      rd_row;
	logic [COL_W-1:0]      rd_col;
	logic [PIXEL_BITS-1:0] rd_pixel;
	pins_t                 pins;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_hold_q <= RESET_HOLD_DEFAULT;
			row_on_q     <= ROW_ON_DEFAULT;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RESET_HOLD: reset_hold_q <= pwdata[HOLD_W-1:0];
				REG_ROW_ON:     row_on_q     <= pwdata[ROW_ON_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RESET_HOLD: prdata = 32'(reset_hold_q);
			REG_ROW_ON:     prdata = 32'(row_on_q);
			default:        prdata = '0;
		endcase
	end

	// input stage and output register handshake
	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign tick_go  = advance && (op_s1 == OP_TICK);
	assign wr_go    = advance && (op_s1 == OP_WRITE)
		&& (32'(row_s1) < ROWS) && (32'(col_s1) < COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			row_s1   <= pixel_row;
			col_s1   <= pixel_column;
			pixel_s1 <= {red, green, blue};
		end
	end

	lmsd_frame_store #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_frame_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (wr_go),
		.wr_row   (ROW_W'(row_s1)),
		.wr_col   (COL_W'(col_s1)),
		.wr_pixel (pixel_s1),
		.rd_row   (rd_row),
		.rd_col   (rd_col),
		.rd_pixel (rd_pixel)
	);

	lmsd_sequencer #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_sequencer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (tick_go),
		.reset_hold (reset_hold_q),
		.row_on     (row_on_q),
		.pixel      (rd_pixel),
		.pins       (pins),
		.rd_row     (rd_row),
		.rd_col     (rd_col)
	);

	// pin levels only move when the output register is free or draining
	assign out_valid        = out_valid_q;
	assign data_pin         = pins.data;
	assign clock_pin        = pins.clock;
	assign latch_pin        = pins.latch;
	assign bank_pin         = pins.bank;
	assign driver_reset_pin = pins.rst;
	assign row_enables      = pins.rows;

endmodule
